// File: rtl/dvl_pkg.sv
`default_nettype none

package dvl_pkg;

    localparam int FRAC_BITS = 14;

    localparam int NORM_W      = 16;
    localparam int COLOR_W     = 8;
    localparam int GAIN_W      = 15;
    localparam int BOOST_W     = 12;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    localparam int K_W     = FRAC_BITS;
    localparam int PROD_W  = NORM_W + K_W + 1;
    localparam int D_W     = FRAC_BITS + 19;
    localparam int DPOS_W  = D_W - 1;
    localparam int SHAPE_W = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 1;
    localparam int EFF_A   = GAIN_W + SHAPE_W;
    localparam int EFF_B   = 2 * FRAC_BITS + 1;
    localparam int EFF_C   = SHAPE_W + FRAC_BITS;
    localparam int EFF_AB  = (EFF_A > EFF_B) ? EFF_A : EFF_B;
    localparam int EFF_W   = ((EFF_AB > EFF_C) ? EFF_AB : EFF_C) + 1;
    localparam int SUM_W   = COLOR_W + EFF_W + 1;
    localparam int CH_W    = SUM_W - 2 * FRAC_BITS;

    localparam int COLOR_MAX = 255;

    localparam logic [K_W-1:0] K30 = K_W'(((30 << FRAC_BITS) + 50) / 100);
    localparam logic [K_W-1:0] K81 = K_W'(((81 << FRAC_BITS) + 50) / 100);
    localparam logic [K_W-1:0] K50 = K_W'(((50 << FRAC_BITS) + 50) / 100);
    localparam logic [K_W-1:0] K72 = K_W'(((72 << FRAC_BITS) + 50) / 100);
    localparam logic [K_W-1:0] K28 = K_W'(((28 << FRAC_BITS) + 50) / 100);
    localparam logic [K_W-1:0] K62 = K_W'(((62 << FRAC_BITS) + 50) / 100);
    localparam logic [K_W-1:0] K18 = K_W'(((18 << FRAC_BITS) + 50) / 100);
    localparam logic [K_W-1:0] K70 = K_W'(((70 << FRAC_BITS) + 50) / 100);

    localparam logic [GAIN_W-1:0] EXPOSURE_RESET = GAIN_W'(3932);

    localparam logic [MODE_W-1:0] MODE_SCALAR    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OBJECTIVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NIGHT     = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_BASE_RED      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_GREEN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE_BLUE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPOSURE_GAIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_BOOST     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_BOOST   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SHADE_MODE    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TWO_SIDED     = 3'd7;

    typedef struct packed {
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
        logic signed [NORM_W-1:0] normal_z;
    } dvl_normal_t;

    typedef struct packed {
        logic [COLOR_W-1:0] front_red;
        logic [COLOR_W-1:0] front_green;
        logic [COLOR_W-1:0] front_blue;
        logic [COLOR_W-1:0] back_red;
        logic [COLOR_W-1:0] back_green;
        logic [COLOR_W-1:0] back_blue;
    } dvl_color_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } dvl_rgb_t;

    typedef struct packed {
        logic [COLOR_W-1:0] base_red;
        logic [COLOR_W-1:0] base_green;
        logic [COLOR_W-1:0] base_blue;
        logic [GAIN_W-1:0]  exposure_gain;
        logic [BOOST_W-1:0] red_boost;
        logic [BOOST_W-1:0] green_boost;
        logic [MODE_W-1:0]  shade_mode;
        logic               two_sided;
    } dvl_cfg_t;

    typedef struct packed {
        logic shape;
        logic gain;
        logic color;
    } dvl_stage_en_t;

endpackage

`default_nettype wire

// File: rtl/directional_vertex_lighting.sv
// Directional vertex lighting: takes one Q1.14 normal per beat and returns the
// front and back RGB bytes lit against a fixed light direction. The pipeline
// has five register stages (normal products, facing sum, shape multiply, gain
// multiply, color multiply); each result passes through them in that order and
// is held in the color stage until color_ready takes it. A new normal is
// taken every cycle while results drain. A stall on color_ready holds each
// occupied stage with no empty stage after it; others advance into empty ones.
// Configuration writes are always ready and take effect at once, so write them
// only while no normal is in flight.
`default_nettype none

module directional_vertex_lighting
    import dvl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   normal_valid,
    output logic                        normal_ready,
    input  wire dvl_normal_t            normal,
    output logic                        color_valid,
    input  wire logic                   color_ready,
    output dvl_color_t                  color,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    dvl_cfg_t                 cfg_reg;
    dvl_stage_en_t            stage_en;
    logic                     en_prod;
    logic                     en_sum;
    logic                     valid_prod_reg;
    logic                     valid_sum_reg;
    logic                     valid_shape_reg;
    logic                     valid_gain_reg;
    logic                     valid_color_reg;
    logic signed [PROD_W-1:0] px_next;
    logic signed [PROD_W-1:0] py_next;
    logic signed [PROD_W-1:0] pz_next;
    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [PROD_W-1:0] pz_reg;
    logic signed [D_W-1:0]    facing;
    logic [DPOS_W-1:0]        fpos_next;
    logic [DPOS_W-1:0]        bpos_next;
    logic [DPOS_W-1:0]        fpos_reg;
    logic [DPOS_W-1:0]        bpos_reg;
    dvl_rgb_t                 front_rgb;
    dvl_rgb_t                 back_rgb;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg               <= '0;
            cfg_reg.exposure_gain <= EXPOSURE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BASE_RED:      cfg_reg.base_red      <= cfg_data[COLOR_W-1:0];
                REG_BASE_GREEN:    cfg_reg.base_green    <= cfg_data[COLOR_W-1:0];
                REG_BASE_BLUE:     cfg_reg.base_blue     <= cfg_data[COLOR_W-1:0];
                REG_EXPOSURE_GAIN: cfg_reg.exposure_gain <= cfg_data[GAIN_W-1:0];
                REG_RED_BOOST:     cfg_reg.red_boost     <= cfg_data[BOOST_W-1:0];
                REG_GREEN_BOOST:   cfg_reg.green_boost   <= cfg_data[BOOST_W-1:0];
                REG_SHADE_MODE:    cfg_reg.shade_mode    <= cfg_data[MODE_W-1:0];
                REG_TWO_SIDED:     cfg_reg.two_sided     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // advance a stage when it is empty or its contents move on
    always_comb
    begin
        stage_en.color = !valid_color_reg || color_ready;
        stage_en.gain  = !valid_gain_reg || stage_en.color;
        stage_en.shape = !valid_shape_reg || stage_en.gain;
        en_sum         = !valid_sum_reg || stage_en.shape;
        en_prod        = !valid_prod_reg || en_sum;
    end

    assign normal_ready = en_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_prod_reg  <= 1'b0;
            valid_sum_reg   <= 1'b0;
            valid_shape_reg <= 1'b0;
            valid_gain_reg  <= 1'b0;
            valid_color_reg <= 1'b0;
        end
        else
        begin
            if (en_prod)
            begin
                valid_prod_reg <= normal_valid;
            end
            if (en_sum)
            begin
                valid_sum_reg <= valid_prod_reg;
            end
            if (stage_en.shape)
            begin
                valid_shape_reg <= valid_sum_reg;
            end
            if (stage_en.gain)
            begin
                valid_gain_reg <= valid_shape_reg;
            end
            if (stage_en.color)
            begin
                valid_color_reg <= valid_gain_reg;
            end
        end
    end

    always_comb
    begin
        px_next = normal.normal_x * $signed({1'b0, K30});
        py_next = normal.normal_y * $signed({1'b0, K81});
        pz_next = normal.normal_z * $signed({1'b0, K50});
    end

    always_comb
    begin
        facing    = D_W'(px_reg) + D_W'(py_reg) - D_W'(pz_reg);
        fpos_next = (facing > 0) ? DPOS_W'(facing) : '0;
        bpos_next = (facing < 0) ? DPOS_W'(-facing) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
        end
        if (en_sum)
        begin
            fpos_reg <= fpos_next;
            bpos_reg <= bpos_next;
        end
    end

    dvl_shade u_front (
        .clk      (clk),
        .cfg      (cfg_reg),
        .stage_en (stage_en),
        .dpos     (fpos_reg),
        .rgb      (front_rgb)
    );

    dvl_shade u_back (
        .clk      (clk),
        .cfg      (cfg_reg),
        .stage_en (stage_en),
        .dpos     (bpos_reg),
        .rgb      (back_rgb)
    );

    always_comb
    begin
        color_valid       = valid_color_reg;
        color.front_red   = front_rgb.red;
        color.front_green = front_rgb.green;
        color.front_blue  = front_rgb.blue;
        color.back_red    = cfg_reg.two_sided ? back_rgb.red   : front_rgb.red;
        color.back_green  = cfg_reg.two_sided ? back_rgb.green : front_rgb.green;
        color.back_blue   = cfg_reg.two_sided ? back_rgb.blue  : front_rgb.blue;
    end

endmodule

`default_nettype wire

// File: rtl/dvl_shade.sv
`default_nettype none

module dvl_shade
    import dvl_pkg::*;
(
    input  wire logic              clk,
    input  wire dvl_cfg_t          cfg,
    input  wire dvl_stage_en_t     stage_en,
    input  wire logic [DPOS_W-1:0] dpos,
    output dvl_rgb_t               rgb
);

    function automatic logic [COLOR_W-1:0] scale_color(
        input logic [COLOR_W-1:0] base,
        input logic [EFF_W-1:0]   eff,
        input logic [BOOST_W-1:0] boost
    );
        logic [COLOR_W+EFF_W-1:0] prod;
        logic [SUM_W-1:0]         acc;
        logic [CH_W-1:0]          ch;
        prod = base * eff;
        acc  = SUM_W'(prod) + (SUM_W'(boost) << (2 * FRAC_BITS - 8));
        ch   = acc[SUM_W-1:2*FRAC_BITS];
        return (ch > CH_W'(COLOR_MAX)) ? COLOR_W'(COLOR_MAX) : ch[COLOR_W-1:0];
    endfunction

    logic                     night;
    logic [K_W-1:0]           slope;
    logic [K_W-1:0]           offset;
    logic [K_W+DPOS_W-1:0]    slope_prod;
    logic [SHAPE_W-1:0]       shape_next;
    logic [SHAPE_W-1:0]       shape_reg;
    logic [GAIN_W+SHAPE_W-1:0] gain_prod;
    logic [K_W+SHAPE_W-1:0]   obj_prod;
    logic [EFF_W-1:0]         eff_next;
    logic [EFF_W-1:0]         eff_reg;
    logic [BOOST_W-1:0]       red_add;
    logic [BOOST_W-1:0]       grn_offset;
    dvl_rgb_t                 rgb_next;
    dvl_rgb_t                 rgb_reg;

    assign night = (cfg.shade_mode == MODE_NIGHT);

    always_comb
    begin
        slope      = night ? K30 : K28;
        offset     = night ? K70 : K72;
        slope_prod = slope * dpos;
        shape_next = SHAPE_W'(offset) + SHAPE_W'(slope_prod >> (2 * FRAC_BITS));
    end

    always_comb
    begin
        gain_prod = cfg.exposure_gain * shape_reg;
        obj_prod  = K18 * shape_reg;
        case (cfg.shade_mode)
            MODE_NIGHT:
            begin
                eff_next = EFF_W'(shape_reg) << FRAC_BITS;
            end
            MODE_OBJECTIVE:
            begin
                eff_next = EFF_W'(obj_prod) + (EFF_W'(K62) << FRAC_BITS);
            end
            MODE_SCALAR:
            begin
                eff_next = EFF_W'(gain_prod);
            end
            default:
            begin
                eff_next = EFF_W'(gain_prod);
            end
        endcase
    end

    always_comb
    begin
        red_add        = night ? '0 : cfg.red_boost;
        grn_offset     = night ? '0 : cfg.green_boost;
        rgb_next.red   = scale_color(cfg.base_red, eff_reg, red_add);
        rgb_next.green = scale_color(cfg.base_green, eff_reg, grn_offset);
        rgb_next.blue  = scale_color(cfg.base_blue, eff_reg, '0);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en.shape)
        begin
            shape_reg <= shape_next;
        end
        if (stage_en.gain)
        begin
            eff_reg <= eff_next;
        end
        if (stage_en.color)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb = rgb_reg;

endmodule

`default_nettype wire

// File: rtl/dvl_checker.sv
`default_nettype none

module dvl_checker
    import dvl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   normal_ready,
    input  wire logic                   color_valid,
    input  wire logic                   color_ready,
    input  wire dvl_color_t             color,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic two_sided_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_sided_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready && (cfg_index == REG_TWO_SIDED))
        begin
            two_sided_reg <= cfg_data[0];
        end
    end

    // hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && !color_ready |=> color_valid && $stable(color))
        else $error("stalled color beat changed or dropped");

    // an empty output stage never blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !color_valid |-> normal_ready)
        else $error("input blocked while output stage empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        color_valid && !two_sided_reg |->
            (color.back_red == color.front_red) &&
            (color.back_green == color.front_green) &&
            (color.back_blue == color.front_blue))
        else $error("back color differs from front in one-sided mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write not taken");

endmodule

bind directional_vertex_lighting dvl_checker u_dvl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .normal_ready (normal_ready),
    .color_valid  (color_valid),
    .color_ready  (color_ready),
    .color        (color),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
);

`default_nettype wire
